// ===== src/swhs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the sensor window history statistics block
// no dependencies

package swhs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int FILL_OUT_W = 8;

  localparam logic [TIME_W-1:0] FLUSH_PERIOD_RESET = 32'd180000;

  localparam logic signed [1:0] TREND_DOWN = -2'sd1;
  localparam logic signed [1:0] TREND_FLAT = 2'sd0;
  localparam logic signed [1:0] TREND_UP   = 2'sd1;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic win_update;
    logic div_start;
    logic div_hist;
    logic wavg_load;
    logic hist_push;
    logic scan_step;
    logic hmean_load;
    logic out_load;
  } swhs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic flush_due;
    logic scan_last;
  } swhs_sts_t;

endpackage

// ===== src/swhs_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for sample input and statistics output
// no dependencies

interface swhs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic        [31:0] now_ms;
  modport source (output valid, sample, now_ms, input ready);
  modport sink   (input valid, sample, now_ms, output ready);
endinterface

interface swhs_out_if;
  logic               valid;
  logic               ready;
  logic signed [1:0]  trend;
  logic               flushed;
  logic signed [15:0] pushed_average;
  logic signed [15:0] history_average;
  logic signed [15:0] history_min;
  logic signed [15:0] history_max;
  logic        [15:0] history_delta;
  logic        [7:0]  history_fill;
  modport source (output valid, trend, flushed, pushed_average, history_average,
                  history_min, history_max, history_delta, history_fill,
                  input ready);
  modport sink   (input valid, trend, flushed, pushed_average, history_average,
                  history_min, history_max, history_delta, history_fill,
                  output ready);
endinterface

// ===== src/swhs_div.sv =====
`timescale 1ns / 1ps
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncating
// no dependencies

module swhs_div #(
  parameter int NW = 29,
  parameter int DW = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] dividend,
  input  logic        [DW-1:0] divisor,
  output logic                 done,
  output logic signed [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] mag;
  logic [DW:0]   rem;
  logic [DW-1:0] dvs;
  logic          neg;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh   = {rem[DW-1:0], mag[NW-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mag  <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
        neg  <= dividend[NW-1];
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
        mag <= {mag[NW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/swhs_datapath.sv =====
`timescale 1ns / 1ps
// window and history stores, running sums, min/max scan and result registers
// depends on swhs_pkg and swhs_div

module swhs_datapath #(
  parameter int WINDOW_DEPTH  = 100,
  parameter int HISTORY_DEPTH = 240
) (
  input  logic                clk,
  input  logic                rst,
  input  swhs_pkg::swhs_cmd_t cmd,
  output swhs_pkg::swhs_sts_t sts,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic signed [15:0]  in_sample,
  input  logic [31:0]         in_now_ms,
  output logic signed [1:0]   out_trend,
  output logic                out_flushed,
  output logic signed [15:0]  out_pushed_average,
  output logic signed [15:0]  out_history_average,
  output logic signed [15:0]  out_history_min,
  output logic signed [15:0]  out_history_max,
  output logic [15:0]         out_history_delta,
  output logic [7:0]          out_history_fill
);

  import swhs_pkg::*;

  localparam int WA     = $clog2(WINDOW_DEPTH);
  localparam int HA     = $clog2(HISTORY_DEPTH);
  localparam int WCNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int WSUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int HSUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH);
  localparam int NW     = (WSUM_W > HSUM_W) ? WSUM_W : HSUM_W;
  localparam int DW     = (WCNT_W > HCNT_W) ? WCNT_W : HCNT_W;

  logic signed [SAMPLE_W-1:0] wmem [WINDOW_DEPTH];
  logic signed [SAMPLE_W-1:0] hmem [HISTORY_DEPTH];

  logic [TIME_W-1:0]          flush_period;
  logic [TIME_W-1:0]          last_flush;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [TIME_W-1:0]          now_r;
  logic signed [SAMPLE_W-1:0] wrd;
  logic [WA-1:0]              whead;
  logic [WCNT_W-1:0]          wfill;
  logic signed [WSUM_W-1:0]   wsum;
  logic signed [WSUM_W-1:0]   wsum_next;
  logic                       wfull;
  logic [HA-1:0]              hhead;
  logic [HCNT_W-1:0]          hfill;
  logic [HA-1:0]              scan_addr;
  logic                       scan_vld;
  logic                       scan_first;
  logic signed [SAMPLE_W-1:0] hrd;
  logic signed [HSUM_W-1:0]   hsum;
  logic signed [SAMPLE_W-1:0] hmean;
  logic signed [SAMPLE_W-1:0] hlow;
  logic signed [SAMPLE_W-1:0] hhigh;
  logic signed [SAMPLE_W-1:0] wavg;
  logic signed [SAMPLE_W-1:0] q16;
  logic signed [1:0]          trend_r;
  logic                       flushed_r;
  logic signed [NW-1:0]       div_a;
  logic [DW-1:0]              div_b;
  logic signed [NW-1:0]       div_q;

  assign wfull     = wfill == WCNT_W'(WINDOW_DEPTH);
  assign wsum_next = wsum + WSUM_W'(sample_r)
                   - (wfull ? WSUM_W'(wrd) : WSUM_W'(0));

  assign sts.flush_due = (now_r - last_flush) > flush_period;
  assign sts.scan_last = scan_addr == HA'(hfill - 1'b1);

  assign div_a = cmd.div_hist ? NW'(hsum) : NW'(wsum);
  assign div_b = cmd.div_hist ? DW'(hfill) : DW'(wfill);
  assign q16   = div_q[SAMPLE_W-1:0];

  swhs_div #(.NW(NW), .DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (sts.div_done),
    .quotient (div_q)
  );

  // stores: registered reads
  always_ff @(posedge clk) begin
    wrd <= wmem[whead];
    hrd <= hmem[scan_addr];
    if (cmd.win_update) wmem[whead] <= sample_r;
    if (cmd.hist_push)  hmem[hhead] <= wavg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_period <= FLUSH_PERIOD_RESET;
      last_flush   <= '0;
      whead        <= '0;
      wfill        <= '0;
      wsum         <= '0;
      hhead        <= '0;
      hfill        <= '0;
      hmean        <= '0;
      hlow         <= '0;
      hhigh        <= '0;
      scan_addr    <= '0;
      scan_vld     <= 1'b0;
      scan_first   <= 1'b0;
    end else begin
      if (cfg_we) flush_period <= cfg_wdata;
      if (cmd.capture) begin
        sample_r <= in_sample;
        now_r    <= in_now_ms;
      end
      if (cmd.win_update) begin
        wsum  <= wsum_next;
        whead <= (whead == WA'(WINDOW_DEPTH - 1)) ? '0 : whead + 1'b1;
        if (!wfull) wfill <= wfill + 1'b1;
      end
      if (cmd.wavg_load) begin
        wavg      <= q16;
        flushed_r <= sts.flush_due;
        if (q16 > hmean)      trend_r <= TREND_UP;
        else if (q16 < hmean) trend_r <= TREND_DOWN;
        else                  trend_r <= TREND_FLAT;
      end
      if (cmd.hist_push) begin
        last_flush <= now_r;
        wfill      <= '0;
        wsum       <= '0;
        hhead      <= (hhead == HA'(HISTORY_DEPTH - 1)) ? '0 : hhead + 1'b1;
        if (hfill != HCNT_W'(HISTORY_DEPTH)) hfill <= hfill + 1'b1;
        scan_addr  <= '0;
        scan_first <= 1'b1;
      end else if (cmd.scan_step) begin
        scan_addr <= scan_addr + 1'b1;
      end
      scan_vld <= cmd.scan_step;
      // accumulate the entry returned by the registered history read
      if (scan_vld) begin
        scan_first <= 1'b0;
        if (scan_first) begin
          hsum  <= HSUM_W'(hrd);
          hlow  <= hrd;
          hhigh <= hrd;
        end else begin
          hsum <= hsum + HSUM_W'(hrd);
          if (hrd < hlow)  hlow  <= hrd;
          if (hrd > hhigh) hhigh <= hrd;
        end
      end
      if (cmd.hmean_load) hmean <= q16;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_trend           <= trend_r;
      out_flushed         <= flushed_r;
      out_pushed_average  <= flushed_r ? wavg : '0;
      out_history_average <= hmean;
      out_history_min     <= hlow;
      out_history_max     <= hhigh;
      out_history_delta   <= 16'(hhigh - hlow);
      out_history_fill    <= FILL_OUT_W'(hfill);
    end
  end

endmodule

// ===== src/swhs_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine for one sample: window update, divides, history scan
// depends on swhs_pkg

module swhs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output swhs_pkg::swhs_cmd_t cmd,
  input  swhs_pkg::swhs_sts_t sts
);

  import swhs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WIN, S_WDIV, S_WWAIT, S_PUSH, S_SCAN, S_DRAIN, S_HDIV, S_HWAIT, S_OUT
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = state == S_IDLE;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.capture    = state == S_IDLE && in_valid;
    cmd.win_update = state == S_WIN;
    cmd.div_start  = state == S_WDIV || state == S_HDIV;
    cmd.div_hist   = state == S_HDIV;
    cmd.wavg_load  = state == S_WWAIT && sts.div_done;
    cmd.hist_push  = state == S_PUSH;
    cmd.scan_step  = state == S_SCAN;
    cmd.hmean_load = state == S_HWAIT && sts.div_done;
    cmd.out_load   = state == S_OUT && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_WIN;
        S_WIN:   state <= S_WDIV;
        S_WDIV:  state <= S_WWAIT;
        S_WWAIT: if (sts.div_done) state <= sts.flush_due ? S_PUSH : S_OUT;
        S_PUSH:  state <= S_SCAN;
        S_SCAN:  if (sts.scan_last) state <= S_DRAIN;
        S_DRAIN: state <= S_HDIV;
        S_HDIV:  state <= S_HWAIT;
        S_HWAIT: if (sts.div_done) state <= S_OUT;
        S_OUT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sensor_window_history_stats_top.sv =====
`timescale 1ns / 1ps
// top level of the sensor window history statistics block
// depends on swhs_pkg, swhs_if, swhs_ctrl, swhs_datapath
//
//  channel | dir | fields
//  --------+-----+--------------------------------------------------------------
//  in      | in  | sample, now_ms
//  out     | out | trend, flushed, pushed_average, history_average/min/max/
//          |     | delta, history_fill
//  cfg     | in  | cfg_we, cfg_wdata (flush_period_ms)
//
// one sample at a time; without a flush an item takes a window update and a divide of
// NW bits, where NW = 16 + clog2(max depth) is the bit count of the shared serial
// divider (24 at default depths); a flush adds a history scan of one entry per cycle
// plus a second divide.
// synchronous reset, no clearing pass; a new sample is taken while a result waits,
// and the next result holds in the sequencer until the output register frees.

module sensor_window_history_stats_top #(
  parameter int WINDOW_DEPTH  = 100,
  parameter int HISTORY_DEPTH = 240
) (
  input  logic        clk,
  input  logic        rst,
  swhs_in_if.sink     in,
  swhs_out_if.source  out,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  import swhs_pkg::*;

  swhs_cmd_t cmd;
  swhs_sts_t sts;

  swhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  swhs_datapath #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_sample           (in.sample),
    .in_now_ms           (in.now_ms),
    .out_trend           (out.trend),
    .out_flushed         (out.flushed),
    .out_pushed_average  (out.pushed_average),
    .out_history_average (out.history_average),
    .out_history_min     (out.history_min),
    .out_history_max     (out.history_max),
    .out_history_delta   (out.history_delta),
    .out_history_fill    (out.history_fill)
  );

endmodule
